/* hw/rtl/msd_pkg.sv */
// msd_pkg: shared constants, register indexes and the result record of the
// magic-sync message deframer. No dependencies.
`default_nettype none

package msd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned PosW       = 16;
  localparam int unsigned MagicCount = 4;
  localparam int unsigned HeaderBytes = 6;

  localparam logic [ByteW-1:0] MagicByte   = 8'h7E;
  localparam logic [WordW-1:0] ForwardReset = 16'h0C01;

  // framing phase codes; the spare code acts as hunt
  localparam logic [1:0] PhHunt   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhData   = 2'd2;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = WordW;
  localparam logic [CfgIdxW-1:0] RegExpectedType = 1'b0;
  localparam logic [CfgIdxW-1:0] RegForwardType  = 1'b1;

  // header byte positions
  localparam logic [2:0] HdrTypeHi = 3'd0;
  localparam logic [2:0] HdrTypeLo = 3'd1;
  localparam logic [2:0] HdrLenHi  = 3'd2;
  localparam logic [2:0] HdrLenLo  = 3'd3;
  localparam logic [2:0] HdrSumHi  = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             payload_valid;
    logic             payload_last;
    logic             header_done;
    logic [WordW-1:0] frame_type;
    logic [WordW-1:0] msg_length;
    logic             response_match;
  } msd_result_t;

endpackage

`default_nettype wire

/* hw/rtl/msd_if.sv */
// msd_in_if / msd_out_if: valid-ready channels carrying received bytes in and
// deframer results out. Depends on msd_pkg.
`default_nettype none

interface msd_in_if;
  logic                       valid;
  logic                       ready;
  logic [msd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msd_out_if;
  logic                       valid;
  logic                       ready;
  logic [msd_pkg::ByteW-1:0]  out_byte;
  logic                       payload_valid;
  logic                       payload_last;
  logic                       header_done;
  logic [msd_pkg::WordW-1:0]  frame_type;
  logic [msd_pkg::WordW-1:0]  msg_length;
  logic                       response_match;

  modport source (output valid, output out_byte, output payload_valid,
                  output payload_last, output header_done, output frame_type,
                  output msg_length, output response_match, input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input payload_last, input header_done, input frame_type,
                  input msg_length, input response_match, output ready);
endinterface

`default_nettype wire

/* hw/rtl/msd_core.sv */
// msd_core: framing state, configuration registers and the per-byte next
// state / result logic. Depends on msd_pkg.
`default_nettype none

module msd_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [msd_pkg::ByteW-1:0]     rx_byte,
  input  wire logic                          cfg_wr_en,
  input  wire logic [msd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [msd_pkg::CfgDataW-1:0]  cfg_data,
  output msd_pkg::msd_result_t               result
);

  logic [msd_pkg::WordW-1:0] expected_type;
  logic [msd_pkg::WordW-1:0] forward_type;
  logic [1:0]                phase;
  logic [msd_pkg::PosW-1:0]  position;
  logic [msd_pkg::WordW-1:0] header_type;
  logic [msd_pkg::WordW-1:0] header_length;
  logic [msd_pkg::WordW-1:0] header_checksum;
  logic                      response_armed;

  logic [1:0]                phase_next;
  logic [msd_pkg::PosW-1:0]  position_next;
  logic [msd_pkg::WordW-1:0] header_type_next;
  logic [msd_pkg::WordW-1:0] header_length_next;
  logic [msd_pkg::WordW-1:0] header_checksum_next;
  logic                      response_armed_next;
  logic [msd_pkg::PosW:0]    pos_inc;

  assign pos_inc = {1'b0, position} + 17'd1;

  always_comb begin
    phase_next           = phase;
    position_next        = position;
    header_type_next     = header_type;
    header_length_next   = header_length;
    header_checksum_next = header_checksum;
    response_armed_next  = response_armed;
    result.out_byte       = rx_byte;
    result.payload_valid  = 1'b0;
    result.payload_last   = 1'b0;
    result.header_done    = 1'b0;
    result.response_match = 1'b0;

    unique case (phase)
      msd_pkg::PhHeader: begin
        case (position[2:0])
          msd_pkg::HdrTypeHi: header_type_next[15:8]     = rx_byte;
          msd_pkg::HdrTypeLo: header_type_next[7:0]      = rx_byte;
          msd_pkg::HdrLenHi:  header_length_next[15:8]   = rx_byte;
          msd_pkg::HdrLenLo:  header_length_next[7:0]    = rx_byte;
          msd_pkg::HdrSumHi:  header_checksum_next[15:8] = rx_byte;
          default:            header_checksum_next[7:0]  = rx_byte;
        endcase
        if (pos_inc >= 17'(msd_pkg::HeaderBytes)) begin
          result.header_done = 1'b1;
          position_next      = '0;
          if (response_armed && (expected_type != '0) &&
              (header_type_next == expected_type)) begin
            result.response_match = 1'b1;
            response_armed_next   = 1'b0;
          end
          phase_next = (header_length_next == '0) ? msd_pkg::PhHunt : msd_pkg::PhData;
        end else begin
          position_next = pos_inc[msd_pkg::PosW-1:0];
        end
      end
      msd_pkg::PhData: begin
        result.payload_valid = (header_type == forward_type);
        if (pos_inc >= {1'b0, header_length}) begin
          result.payload_last = 1'b1;
          position_next       = '0;
          phase_next          = msd_pkg::PhHunt;
        end else begin
          position_next = pos_inc[msd_pkg::PosW-1:0];
        end
      end
      default: begin
        // hunt: count consecutive magic bytes
        phase_next = msd_pkg::PhHunt;
        if (rx_byte == msd_pkg::MagicByte) begin
          if (pos_inc >= 17'(msd_pkg::MagicCount)) begin
            position_next = '0;
            phase_next    = msd_pkg::PhHeader;
          end else begin
            position_next = pos_inc[msd_pkg::PosW-1:0];
          end
        end else begin
          position_next = '0;
        end
      end
    endcase

    result.frame_type = header_type_next;
    result.msg_length = header_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type   <= '0;
      forward_type    <= msd_pkg::ForwardReset;
      phase           <= msd_pkg::PhHunt;
      position        <= '0;
      header_type     <= '0;
      header_length   <= '0;
      header_checksum <= '0;
      response_armed  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          msd_pkg::RegExpectedType: begin
            expected_type  <= cfg_data;
            response_armed <= 1'b1;
          end
          msd_pkg::RegForwardType: begin
            forward_type <= cfg_data;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        response_armed <= response_armed_next;
      end
      if (accept) begin
        phase           <= phase_next;
        position        <= position_next;
        header_type     <= header_type_next;
        header_length   <= header_length_next;
        header_checksum <= header_checksum_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/msd_skid.sv */
// msd_skid: two-entry result register (output register plus skid entry) so
// the input side keeps taking bytes while a result waits. Depends on msd_pkg.
`default_nettype none

module msd_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  msd_pkg::msd_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output msd_pkg::msd_result_t out_data
);

  logic                 main_valid;
  msd_pkg::msd_result_t main_data;
  logic                 skid_valid;
  msd_pkg::msd_result_t skid_data;
  logic                 pop;

  assign pop        = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      main_data <= skid_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/magic_sync_message_deframer.sv */
// magic_sync_message_deframer: top level, byte stream in, one result per byte
// out. Depends on msd_pkg, msd_if, msd_core and msd_skid.
//
// Takes one received byte per cycle while ready and returns exactly one
// result for it. Each byte is decoded in the same cycle it is accepted
// (hunt for four '~' bytes, six-byte big-endian header, then length payload
// bytes); its result is registered in a two-entry output register. The input
// stays ready as long as the skid entry is free, so a full byte per cycle is
// sustained whenever the sink keeps up, and one stalled result does not block
// the next byte. Configuration writes take effect on the next clock edge and
// are meant to happen only while no byte is in flight; writing expected_type
// re-arms the single-shot response_match flag.
`default_nettype none

module magic_sync_message_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  msd_in_if.sink                             in_ch,
  msd_out_if.source                          out_ch,
  input  wire logic                          cfg_wr_en,
  input  wire logic [msd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [msd_pkg::CfgDataW-1:0]  cfg_data
);

  logic                 accept;
  logic                 push_ready;
  msd_pkg::msd_result_t result;
  msd_pkg::msd_result_t out_data;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  msd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  msd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.out_byte       = out_data.out_byte;
  assign out_ch.payload_valid  = out_data.payload_valid;
  assign out_ch.payload_last   = out_data.payload_last;
  assign out_ch.header_done    = out_data.header_done;
  assign out_ch.frame_type     = out_data.frame_type;
  assign out_ch.msg_length     = out_data.msg_length;
  assign out_ch.response_match = out_data.response_match;

endmodule

`default_nettype wire

/* hw/rtl/msd_checker.sv */
// msd_checker: port-level assertions for the deframer, bound to the top
// level. Depends on msd_pkg and magic_sync_message_deframer.
`default_nettype none

module msd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [msd_pkg::ByteW-1:0] out_byte,
  input wire logic                      payload_valid,
  input wire logic                      payload_last,
  input wire logic                      header_done,
  input wire logic                      response_match
);

  // input only stalls when both result entries are occupied
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a header byte is never a payload byte
  a_header_not_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> !payload_valid && !payload_last)
    else $error("header completion flagged as payload");

  a_match_on_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && response_match |-> header_done)
    else $error("response match without completed header");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled result dropped or changed");

endmodule

bind magic_sync_message_deframer msd_checker u_msd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .payload_valid  (out_ch.payload_valid),
  .payload_last   (out_ch.payload_last),
  .header_done    (out_ch.header_done),
  .response_match (out_ch.response_match)
);

`default_nettype wire

/* sim/magic_sync_message_deframer_test.sv */
// magic_sync_message_deframer_test: self-checking bench for the magic-sync message deframer.
// Drives bytes in, predicts every result in a local model, compares field by field.
// Depends on msd_pkg, msd_if and the deframer RTL.

module magic_sync_message_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandomBytes = 220;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [msd_pkg::CfgIdxW-1:0]  cfg_index;
  logic [msd_pkg::CfgDataW-1:0] cfg_data;

  msd_in_if  in_ch ();
  msd_out_if out_ch ();

  magic_sync_message_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the framing state and registers
  logic [1:0]                fr_phase;
  logic [msd_pkg::PosW-1:0]  fr_pos;
  logic [msd_pkg::WordW-1:0] hdr_type;
  logic [msd_pkg::WordW-1:0] hdr_len;
  logic [msd_pkg::WordW-1:0] hdr_sum;
  logic                      resp_armed;
  logic [msd_pkg::WordW-1:0] reg_expected;
  logic [msd_pkg::WordW-1:0] reg_forward;

  msd_pkg::msd_result_t awaited_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int n_bytes;
  int n_results;
  int n_headers;
  int n_forwarded;
  int n_matches;
  int n_errors;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    fr_phase     = msd_pkg::PhHunt;
    fr_pos       = '0;
    hdr_type     = '0;
    hdr_len      = '0;
    hdr_sum      = '0;
    resp_armed   = 1'b1;
    reg_expected = '0;
    reg_forward  = msd_pkg::ForwardReset;
  endfunction

  function automatic void apply_reg(logic [msd_pkg::CfgIdxW-1:0] idx,
                                    logic [msd_pkg::CfgDataW-1:0] data);
    if (idx == msd_pkg::RegExpectedType) begin
      reg_expected = data;
      resp_armed   = 1'b1;
    end else if (idx == msd_pkg::RegForwardType) begin
      reg_forward = data;
    end
  endfunction

  // advances the framing state by one byte and returns the result it causes
  function automatic msd_pkg::msd_result_t deframe_byte(logic [msd_pkg::ByteW-1:0] b);
    msd_pkg::msd_result_t r;
    r = '0;
    r.out_byte = b;
    case (fr_phase)
      msd_pkg::PhHeader: begin
        case (fr_pos)
          msd_pkg::HdrTypeHi: hdr_type[15:8] = b;
          msd_pkg::HdrTypeLo: hdr_type[7:0]  = b;
          msd_pkg::HdrLenHi:  hdr_len[15:8]  = b;
          msd_pkg::HdrLenLo:  hdr_len[7:0]   = b;
          msd_pkg::HdrSumHi:  hdr_sum[15:8]  = b;
          default:            hdr_sum[7:0]   = b;
        endcase
        if (fr_pos + 1 >= msd_pkg::HeaderBytes) begin
          r.header_done = 1'b1;
          fr_pos = '0;
          if (resp_armed && reg_expected != 0 && hdr_type == reg_expected) begin
            r.response_match = 1'b1;
            resp_armed = 1'b0;
          end
          fr_phase = (hdr_len == 0) ? msd_pkg::PhHunt : msd_pkg::PhData;
        end else begin
          fr_pos = fr_pos + 1'b1;
        end
      end
      msd_pkg::PhData: begin
        r.payload_valid = (hdr_type == reg_forward);
        if (fr_pos + 1 >= 32'(hdr_len)) begin
          r.payload_last = 1'b1;
          fr_pos = '0;
          fr_phase = msd_pkg::PhHunt;
        end else begin
          fr_pos = fr_pos + 1'b1;
        end
      end
      default: begin
        // spare phase code falls back to hunting as well
        fr_phase = msd_pkg::PhHunt;
        if (b == msd_pkg::MagicByte) begin
          fr_pos = fr_pos + 1'b1;
          if (fr_pos >= msd_pkg::MagicCount) begin
            fr_pos = '0;
            fr_phase = msd_pkg::PhHeader;
          end
        end else begin
          fr_pos = '0;
        end
      end
    endcase
    r.frame_type = hdr_type;
    r.msg_length = hdr_len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [msd_pkg::WordW-1:0] want,
                                      logic [msd_pkg::WordW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // sink side: random stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // request capture, result check and watchdog in one process so that
  // a request and a result at the same edge are always seen in order
  always @(posedge clk) begin
    msd_pkg::msd_result_t got;
    msd_pkg::msd_result_t want;
    bit                   busy;
    busy = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(deframe_byte(in_ch.rx_byte));
        busy = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        busy = 1'b1;
        n_results++;
        got.out_byte       = out_ch.out_byte;
        got.payload_valid  = out_ch.payload_valid;
        got.payload_last   = out_ch.payload_last;
        got.header_done    = out_ch.header_done;
        got.frame_type     = out_ch.frame_type;
        got.msg_length     = out_ch.msg_length;
        got.response_match = out_ch.response_match;
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with no request outstanding, actual %h", $time, got);
          n_errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("payload_valid", want.payload_valid, got.payload_valid);
          check_field("payload_last", want.payload_last, got.payload_last);
          check_field("header_done", want.header_done, got.header_done);
          check_field("frame_type", want.frame_type, got.frame_type);
          check_field("msg_length", want.msg_length, got.msg_length);
          check_field("response_match", want.response_match, got.response_match);
          if (want.header_done) n_headers++;
          if (want.payload_valid) n_forwarded++;
          if (want.response_match) n_matches++;
        end
      end
      if (cfg_wr_en) busy = 1'b1;
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                   $time, idle_cycles, awaited_results.size());
          $display("FAIL magic_sync_message_deframer");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [msd_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_bytes++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [msd_pkg::CfgIdxW-1:0] idx,
                           input logic [msd_pkg::CfgDataW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_header(input logic [msd_pkg::WordW-1:0] ftype,
                             input logic [msd_pkg::WordW-1:0] flen,
                             input logic [msd_pkg::WordW-1:0] fsum);
    repeat (msd_pkg::MagicCount) send_byte(msd_pkg::MagicByte);
    send_byte(ftype[15:8]);
    send_byte(ftype[7:0]);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    send_byte(fsum[15:8]);
    send_byte(fsum[7:0]);
  endtask

  function automatic logic [msd_pkg::ByteW-1:0] any_byte();
    return ($urandom_range(9) == 0) ? msd_pkg::MagicByte
                                    : msd_pkg::ByteW'($urandom_range(255));
  endfunction

  task automatic send_frame(input logic [msd_pkg::WordW-1:0] ftype,
                            input logic [msd_pkg::WordW-1:0] flen,
                            input int npay);
    send_header(ftype, flen, msd_pkg::WordW'($urandom));
    repeat (npay) send_byte(any_byte());
  endtask

  task automatic test_directed();
    // preamble broken one byte short
    send_byte(msd_pkg::MagicByte);
    send_byte(msd_pkg::MagicByte);
    send_byte(msd_pkg::MagicByte);
    send_byte(8'h00);
    // forwarded message with extreme payload bytes and an all-ones checksum
    send_header(msd_pkg::ForwardReset, 16'd2, 16'hFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    // a fifth tilde becomes the first header byte; zero length goes back to hunt
    send_header({msd_pkg::MagicByte, 8'h80}, 16'd0, 16'h0000);
  endtask

  task automatic test_responses();
    wait_idle();
    write_reg(msd_pkg::RegExpectedType, 16'h1234);
    send_frame(16'h1234, 16'd1, 1);
    // already consumed, no second match
    send_frame(16'h1234, 16'd0, 0);
    wait_idle();
    // forward_type write leaves the response disarmed
    write_reg(msd_pkg::RegForwardType, 16'h1234);
    send_frame(16'h1234, 16'd2, 2);
    wait_idle();
    write_reg(msd_pkg::RegExpectedType, 16'h1234);
    send_frame(16'h1234, 16'd0, 0);
    wait_idle();
    write_reg(msd_pkg::RegExpectedType, 16'hFFFF);
    write_reg(msd_pkg::RegForwardType, 16'hFFFF);
    send_frame(16'hFFFF, 16'd2, 2);
    wait_idle();
    // zero expected type never matches even a type-zero header
    write_reg(msd_pkg::RegExpectedType, 16'h0000);
    write_reg(msd_pkg::RegForwardType, 16'h0000);
    send_frame(16'h0000, 16'd1, 1);
    wait_idle();
    write_reg(msd_pkg::RegForwardType, msd_pkg::ForwardReset);
  endtask

  task automatic test_long_frame();
    // length with bit 8 set runs the payload counter past one byte
    send_frame(msd_pkg::ForwardReset, 16'h0101, 16'h0101);
  endtask

  function automatic logic [msd_pkg::WordW-1:0] pick_type();
    case ($urandom_range(5))
      0: return reg_forward;
      1: return reg_expected;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return {msd_pkg::MagicByte, msd_pkg::ByteW'($urandom_range(255))};
      default: return msd_pkg::WordW'($urandom);
    endcase
  endfunction

  function automatic logic [msd_pkg::WordW-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 75) return msd_pkg::WordW'($urandom_range(8, 1));
    if (r < 95) return msd_pkg::WordW'($urandom_range(32, 9));
    return msd_pkg::WordW'($urandom_range(64, 33));
  endfunction

  function automatic logic [msd_pkg::WordW-1:0] pick_reg_value(bit forward);
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return forward ? msd_pkg::ForwardReset : reg_forward;
      default: return msd_pkg::WordW'($urandom);
    endcase
  endfunction

  task automatic test_random(input int idle_pct, input int stall_pct);
    int start;
    int k;
    logic [msd_pkg::WordW-1:0] flen;
    wait_idle();
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    write_reg(msd_pkg::RegExpectedType, pick_reg_value(1'b0));
    write_reg(msd_pkg::RegForwardType, pick_reg_value(1'b1));
    start = n_bytes;
    while (n_bytes - start < RandomBytes) begin
      k = $urandom_range(99);
      if (k < 4) drain();
      if (k < 8) begin
        // line noise
        repeat ($urandom_range(6, 1)) send_byte(any_byte());
      end else if (k < 14) begin
        // preamble cut short
        repeat ($urandom_range(msd_pkg::MagicCount - 1, 1)) send_byte(msd_pkg::MagicByte);
        send_byte(msd_pkg::ByteW'($urandom_range(msd_pkg::MagicByte - 1)));
      end else begin
        flen = pick_length();
        // now and then the payload is truncated and the next frame gets swallowed
        send_frame(pick_type(), flen,
                   ($urandom_range(99) < 8) ? $urandom_range(flen) : int'(flen));
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.rx_byte      = '0;
    out_ch.ready       = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    n_bytes            = 0;
    n_results          = 0;
    n_headers          = 0;
    n_forwarded        = 0;
    n_matches          = 0;
    n_errors           = 0;
    idle_cycles        = 0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_responses();
    test_long_frame();
    test_random(0, 0);
    test_random(80, 0);
    test_random(0, 80);
    test_random(8, 8);

    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d bytes and %0d results: %0d headers, %0d forwarded payload bytes,",
             n_bytes, n_results, n_headers, n_forwarded);
    $display("%0d response matches, over several register settings and idle patterns",
             n_matches);
    if (awaited_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, awaited_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASS magic_sync_message_deframer");
    end else begin
      $display("FAIL magic_sync_message_deframer");
    end
    $finish;
  end

endmodule
